// ----- rtl/s2x_pkg.sv -----
// shared types and constants for the scale2x pixel doubler
package s2x_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // fixed field widths
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int COL_OUT_W  = 11;
  localparam int ROW_W      = 12;
  localparam int PORT_PIX_W = 32;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT   = 13'd4096;

  // quad slots of one source pixel, in emission order
  localparam int QUAD_ABOVE = 0;
  localparam int QUAD_LAG   = 1;
  localparam int QUAD_FINAL = 2;
  localparam int NUM_QUADS  = 3;

  typedef logic [PORT_PIX_W-1:0] port_pix_t;

  typedef struct packed {
    port_pix_t top_left;
    port_pix_t top_right;
    port_pix_t bottom_left;
    port_pix_t bottom_right;
  } quad_t;

endpackage

// ----- rtl/scale2x_pixel_doubler.sv -----
// scale2x pixel doubler: streaming 2x pixel-art upscaler, one quad per source pixel
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in_     | input     | in_valid/in_stall   | in_pixel (32b, low PIXEL_BITS used)
//  out_    | output    | out_valid/out_stall | four corners, src_col, src_row, frame_last
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index (0 width, 1 height), cfg_data
//
//  rate: one pixel per clock in steady state while out_stall is low; a pixel of the last row
//  gives up to two quads and the final pixel of a frame up to three; the single output
//  register, which takes one quad per clock, sets this figure
//  path: the pixel beat is registered in the pixel stage with its ram reads, then its quad in the output reg
//  reset: counters, output and pipeline valid clear at once; the line stores get no
//  clearing pass, so the block takes beats right after reset
//  stalls: out_stall holds the output register; in_stall rises only while the
//  pending pixel still has quads that cannot move out
module scale2x_pixel_doubler #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [31:0]                      in_pixel,
  // quad output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_top_left,
  output logic [31:0]                      out_top_right,
  output logic [31:0]                      out_bottom_left,
  output logic [31:0]                      out_bottom_right,
  output logic [10:0]                      out_src_col,
  output logic [11:0]                      out_src_row,
  output logic                             out_frame_last,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [s2x_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [s2x_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // column counter / ram address width, and a compare width that also holds the
  // width register and MAX_WIDTH itself
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (CW + 1 > s2x_pkg::WIDTH_W) ? CW + 1 : s2x_pkg::WIDTH_W;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [CW-1:0]         col_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [s2x_pkg::ROW_W-1:0] row_t;

  // scale2x rule: corners copy an edge neighbor only when the cross is not flat
  function automatic s2x_pkg::quad_t scale2x(input pix_t b, input pix_t d, input pix_t e,
                                             input pix_t f, input pix_t h);
    pix_t c0;
    pix_t c1;
    pix_t c2;
    pix_t c3;
    s2x_pkg::quad_t q;
    c0 = e;
    c1 = e;
    c2 = e;
    c3 = e;
    if (b != h && d != f) begin
      c0 = (d == b) ? d : e;
      c1 = (b == f) ? f : e;
      c2 = (d == h) ? d : e;
      c3 = (h == f) ? f : e;
    end
    q.top_left     = s2x_pkg::port_pix_t'(c0);
    q.top_right    = s2x_pkg::port_pix_t'(c1);
    q.bottom_left  = s2x_pkg::port_pix_t'(c2);
    q.bottom_right = s2x_pkg::port_pix_t'(c3);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [s2x_pkg::WIDTH_W-1:0]  width_r;
  logic [s2x_pkg::HEIGHT_W-1:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= s2x_pkg::WIDTH_RESET;
      height_r <= s2x_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (s2x_pkg::cfg_reg_t'(cfg_index))
        s2x_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[s2x_pkg::WIDTH_W-1:0];
        s2x_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, oversize clamps
  cmp_t                         w_raw;
  cmp_t                         w_eff;
  logic [s2x_pkg::HEIGHT_W-1:0] h_eff;

  always_comb begin
    w_raw = cmp_t'(width_r);
    if (w_raw == '0) begin
      w_eff = cmp_t'(1);
    end else if (w_raw > cmp_t'(MAX_WIDTH)) begin
      w_eff = cmp_t'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_r == '0) begin
      h_eff = s2x_pkg::HEIGHT_W'(1);
    end else if (height_r > s2x_pkg::MAX_HEIGHT) begin
      h_eff = s2x_pkg::MAX_HEIGHT;
    end else begin
      h_eff = height_r;
    end
  end

  // ---------------------------------------------------------------------------
  // raster position and store rotation
  // ---------------------------------------------------------------------------
  col_t  col_r;
  row_t  row_r;
  logic  sel_r;        // 0: store a holds the previous row
  pix_t  first_r;      // column 0 pixel of the latest row begun
  logic  accept;
  logic  last_col;
  logic  last_row;
  cmp_t  x_cmp;
  cmp_t  xr_cmp;
  col_t  xr;
  pix_t  pix_in;

  assign pix_in   = in_pixel[PIXEL_BITS-1:0];
  assign x_cmp    = cmp_t'(col_r);
  assign last_col = x_cmp >= (w_eff - cmp_t'(1));
  assign last_row = {1'b0, row_r} >= (h_eff - s2x_pkg::HEIGHT_W'(1));
  // right neighbor clamped to the last column
  assign xr_cmp   = ((x_cmp + cmp_t'(1)) < (w_eff - cmp_t'(1))) ? (x_cmp + cmp_t'(1))
                                                                : (w_eff - cmp_t'(1));
  assign xr       = xr_cmp[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      sel_r <= 1'b0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + row_t'(1);
        sel_r <= ~sel_r;
      end else begin
        col_r <= col_r + col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && col_r == '0) begin
      first_r <= pix_in;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: the older store is read and overwritten at x (read-first gives
  // row y-2), the previous-row store is read one column ahead at xr
  // ---------------------------------------------------------------------------
  pix_t rd_a;
  pix_t rd_b;

  s2x_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_store_a (
    .clk   (clk),
    .we    (accept && sel_r),
    .waddr (col_r),
    .wdata (pix_in),
    .re    (accept),
    .raddr (sel_r ? col_r : xr),
    .rdata (rd_a)
  );

  s2x_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_store_b (
    .clk   (clk),
    .we    (accept && !sel_r),
    .waddr (col_r),
    .wdata (pix_in),
    .re    (accept),
    .raddr (sel_r ? xr : col_r),
    .rdata (rd_b)
  );

  // ---------------------------------------------------------------------------
  // pixel stage: holds one pixel while its quads drain into the output register
  // ---------------------------------------------------------------------------
  logic                           s1_valid_r;
  logic [s2x_pkg::NUM_QUADS-1:0]  s1_pend_r;
  pix_t                           s1_pix_r;
  pix_t                           s1_first_r;
  col_t                           s1_col_r;
  row_t                           s1_row_r;
  logic                           s1_sel_r;
  logic                           s1_x0_r;
  logic                           s1_x2_r;    // x >= 2
  logic                           s1_y1_r;    // y >= 1
  logic                           s1_y2_r;    // y >= 2
  logic                           s1_lastcol_r;
  logic                           s1_lastrow_r;

  // sliding window over the previous row: prev[x-1], prev[x]
  pix_t win_l_r;
  pix_t win_c_r;
  // last two pixels taken, for the lagging last-row quad
  pix_t hist0_r;
  pix_t hist1_r;

  logic [s2x_pkg::NUM_QUADS-1:0] pend_nxt;
  logic [s2x_pkg::NUM_QUADS-1:0] pick;
  logic [s2x_pkg::NUM_QUADS-1:0] remaining;
  logic                          out_free;
  logic                          load;
  logic                          retire;

  assign pend_nxt[s2x_pkg::QUAD_ABOVE] = row_r != '0;
  assign pend_nxt[s2x_pkg::QUAD_LAG]   = last_row && col_r != '0;
  assign pend_nxt[s2x_pkg::QUAD_FINAL] = last_row && last_col;

  assign pick      = s1_pend_r & (~s1_pend_r + s2x_pkg::NUM_QUADS'(1));
  assign remaining = s1_pend_r & ~pick;
  assign out_free  = !out_valid || !out_stall;
  assign load      = s1_valid_r && s1_pend_r != '0 && out_free;
  assign retire    = s1_valid_r && (s1_pend_r == '0 || (out_free && remaining == '0));
  assign in_stall  = s1_valid_r && !retire;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_pend_r  <= '0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      s1_pend_r  <= pend_nxt;
    end else begin
      if (retire) begin
        s1_valid_r <= 1'b0;
      end
      if (load) begin
        s1_pend_r <= remaining;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r     <= pix_in;
      s1_first_r   <= first_r;
      s1_col_r     <= col_r;
      s1_row_r     <= row_r;
      s1_sel_r     <= sel_r;
      s1_x0_r      <= col_r == '0;
      s1_x2_r      <= x_cmp >= cmp_t'(2);
      s1_y1_r      <= row_r != '0;
      s1_y2_r      <= row_r >= row_t'(2);
      s1_lastcol_r <= last_col;
      s1_lastrow_r <= last_row;
    end
  end

  // neighbors of the pending pixel
  pix_t           prev_q;
  pix_t           older_q;
  pix_t           e_up;
  pix_t           d_up;
  pix_t           b_up;
  pix_t           d_lag;
  pix_t           b_lag;
  pix_t           d_fin;
  pix_t           b_fin;
  s2x_pkg::quad_t q_above;
  s2x_pkg::quad_t q_lag;
  s2x_pkg::quad_t q_final;

  assign prev_q  = s1_sel_r ? rd_b : rd_a;
  assign older_q = s1_sel_r ? rd_a : rd_b;
  // column 0 of the row above comes from the saved first pixel
  assign e_up    = s1_x0_r ? s1_first_r : win_c_r;
  assign d_up    = s1_x0_r ? s1_first_r : win_l_r;
  assign b_up    = s1_y2_r ? older_q : e_up;
  assign d_lag   = s1_x2_r ? hist1_r : hist0_r;
  assign b_lag   = s1_y1_r ? win_l_r : hist0_r;
  assign d_fin   = s1_x0_r ? s1_pix_r : hist0_r;
  assign b_fin   = s1_y1_r ? e_up : s1_pix_r;

  assign q_above = scale2x(b_up, d_up, e_up, prev_q, s1_pix_r);
  assign q_lag   = scale2x(b_lag, d_lag, hist0_r, s1_pix_r, hist0_r);
  assign q_final = scale2x(b_fin, d_fin, s1_pix_r, s1_pix_r, s1_pix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
    end else if (retire) begin
      hist1_r <= hist0_r;
      hist0_r <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      win_l_r <= e_up;
      win_c_r <= prev_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic           out_valid_r;
  s2x_pkg::quad_t out_q_r;
  s2x_pkg::quad_t out_q_nxt;
  col_t           out_col_r;
  col_t           out_col_nxt;
  row_t           out_row_r;
  row_t           out_row_nxt;
  logic           out_last_r;
  logic           out_last_nxt;

  always_comb begin
    if (pick[s2x_pkg::QUAD_ABOVE]) begin
      out_q_nxt    = q_above;
      out_col_nxt  = s1_col_r;
      out_row_nxt  = s1_row_r - row_t'(1);
      out_last_nxt = 1'b0;
    end else if (pick[s2x_pkg::QUAD_LAG]) begin
      out_q_nxt    = q_lag;
      out_col_nxt  = s1_col_r - col_t'(1);
      out_row_nxt  = s1_row_r;
      out_last_nxt = 1'b0;
    end else begin
      out_q_nxt    = q_final;
      out_col_nxt  = s1_col_r;
      out_row_nxt  = s1_row_r;
      out_last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q_r    <= out_q_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_top_left     = out_q_r.top_left;
  assign out_top_right    = out_q_r.top_right;
  assign out_bottom_left  = out_q_r.bottom_left;
  assign out_bottom_right = out_q_r.bottom_right;
  assign out_src_col      = s2x_pkg::COL_OUT_W'(out_col_r);
  assign out_src_row      = out_row_r;
  assign out_frame_last   = out_last_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_t'(col_r) < cmp_t'(MAX_WIDTH))
    else $error("column counter past store depth");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_col |=> col_r == '0)
    else $error("column counter did not wrap at row end");

  a_final_pend: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_pend_r[s2x_pkg::QUAD_FINAL] |-> s1_lastrow_r && s1_lastcol_r)
    else $error("flush quad pending off the frame corner");

  a_lag_pend: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_pend_r[s2x_pkg::QUAD_LAG] |-> s1_lastrow_r && !s1_x0_r)
    else $error("lagging quad pending outside the last row");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty pixel stage");

endmodule

// ----- rtl/s2x_ram.sv -----
// generic single-write single-read ram with registered read, read-first
module s2x_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- tb/scale2x_pixel_doubler_test.sv -----
// self-checking testbench for the scale2x pixel doubler: directed table, extreme sizes, random frames
`timescale 1ns / 100ps

module scale2x_pixel_doubler_test;

  // store depth of the block at its default size
  localparam int unsigned STORE_DEPTH   = 2048;
  // quads pass pixel stage and output reg; row 0 pixels may give none, so writes wait this long
  localparam int unsigned SETTLE_CYCLES = 8;
  // hang guard limit on the whole run
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned END_WAIT      = 2000;
  localparam int unsigned RANDOM_PIXELS = 400;
  localparam int unsigned PRINT_CAP     = 40;

  // one expected quad beat, as it shows up on the out_ ports
  typedef struct packed {
    s2x_pkg::quad_t corners;
    logic [10:0]    col;
    logic [11:0]    row;
    logic           last;
  } quad_beat_t;

  // one row of the directed stimulus table
  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    s2x_pkg::cfg_reg_t reg_sel;
    logic [31:0]       value;
    bit                typed;
    quad_beat_t        want;
  } stim_row_t;

  // clock, reset and block ports; the inputs the bench drives start known at time zero
  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [31:0] in_pixel         = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [31:0] out_top_left;
  logic [31:0] out_top_right;
  logic [31:0] out_bottom_left;
  logic [31:0] out_bottom_right;
  logic [10:0] out_src_col;
  logic [11:0] out_src_row;
  logic        out_frame_last;
  logic        cfg_valid        = 1'b0;
  logic        cfg_ready;
  s2x_pkg::cfg_reg_t              cfg_index = s2x_pkg::REG_IMAGE_WIDTH;
  logic [s2x_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state: line stores, position, last-row history and size registers
  logic [31:0]                   store_a [STORE_DEPTH];
  logic [31:0]                   store_b [STORE_DEPTH];
  int unsigned                   col_pos    = 0;
  int unsigned                   row_pos    = 0;
  logic [31:0]                   hist_prev  = '0;
  logic [31:0]                   hist_prev2 = '0;
  bit                            sel        = 1'b0;
  logic [s2x_pkg::WIDTH_W-1:0]   cfg_width  = s2x_pkg::WIDTH_RESET;
  logic [s2x_pkg::HEIGHT_W-1:0]  cfg_height = s2x_pkg::HEIGHT_RESET;

  quad_beat_t  quads_due [$];
  stim_row_t   plan [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned pixels_sent    = 0;
  bit          no_idle        = 1'b0;
  logic [31:0] palette [4];
  int unsigned palette_size   = 0;

  scale2x_pixel_doubler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_left     (out_top_left),
    .out_top_right    (out_top_right),
    .out_bottom_left  (out_bottom_left),
    .out_bottom_right (out_bottom_right),
    .out_src_col      (out_src_col),
    .out_src_row      (out_src_row),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero acts as one, oversize clamps to the store depth / max height
  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w == 0) w = 1;
    if (w > STORE_DEPTH) w = STORE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = cfg_height;
    if (h == 0) h = 1;
    if (h > s2x_pkg::MAX_HEIGHT) h = s2x_pkg::MAX_HEIGHT;
    return h;
  endfunction

  function automatic int unsigned clamp_col(int unsigned c);
    return (c >= STORE_DEPTH) ? STORE_DEPTH - 1 : c;
  endfunction

  // sel low: store_a holds the previous row, store_b the one before it
  function automatic logic [31:0] prev_px(int unsigned i);
    return sel ? store_b[i] : store_a[i];
  endfunction

  function automatic logic [31:0] older_px(int unsigned i);
    return sel ? store_a[i] : store_b[i];
  endfunction

  // scale2x corner rule around center e with neighbors b (up), d (left), f (right), h (down)
  function automatic quad_beat_t make_quad(logic [31:0] b, logic [31:0] d, logic [31:0] e,
                                           logic [31:0] f, logic [31:0] h, int unsigned col,
                                           int unsigned row, bit last);
    quad_beat_t q;
    q.corners = {e, e, e, e};
    if (b != h && d != f) begin
      q.corners.top_left     = (d == b) ? d : e;
      q.corners.top_right    = (b == f) ? f : e;
      q.corners.bottom_left  = (d == h) ? d : e;
      q.corners.bottom_right = (h == f) ? f : e;
    end
    q.col  = col[10:0];
    q.row  = row[11:0];
    q.last = last;
    return q;
  endfunction

  // one accepted pixel: queue the quads it releases, in emission order
  task automatic predict_quads(input logic [31:0] p);
    int unsigned w, h, x, y, xl, xr;
    bit          last_col, last_row;
    logic [31:0] b, d, e;
    w = eff_width();
    h = eff_height();
    x = clamp_col(col_pos);
    y = row_pos;
    last_col = (x >= w - 1);
    last_row = (y >= h - 1);
    xl = (x > 0) ? x - 1 : 0;
    xr = clamp_col((x + 1 < w - 1) ? x + 1 : w - 1);
    // quad of the row above, now that its lower neighbor is known
    if (y >= 1) begin
      b = (y >= 2) ? older_px(x) : prev_px(x);
      quads_due.push_back(make_quad(b, prev_px(xl), prev_px(x), prev_px(xr), p, x, y - 1, 1'b0));
    end
    // the store holding the older row takes the new pixel
    if (sel) store_a[x] = p;
    else store_b[x] = p;
    if (last_row) begin
      // last row runs one pixel behind: the left neighbor now has its right side
      if (x >= 1) begin
        e = hist_prev;
        d = (x >= 2) ? hist_prev2 : e;
        b = (y >= 1) ? prev_px(x - 1) : e;
        quads_due.push_back(make_quad(b, d, e, p, e, x - 1, y, 1'b0));
      end
      // end of frame flushes the final pixel as well
      if (last_col) begin
        d = (x >= 1) ? hist_prev : p;
        b = (y >= 1) ? prev_px(x) : p;
        quads_due.push_back(make_quad(b, d, p, p, p, x, y, 1'b1));
      end
    end
    hist_prev2 = hist_prev;
    hist_prev  = p;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : (y + 1) % 4096;
      sel     = ~sel;
    end else begin
      col_pos = (x + 1) % 2048;
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want,
                             input quad_beat_t exp_q);
    if (got !== want)
      report_mismatch($sformatf("%s of quad (col %0d, row %0d)", name, exp_q.col, exp_q.row),
                      got, want);
  endtask

  // every quad beat taken by the receiver is matched against the oldest expectation
  always @(posedge clk) begin : quad_monitor
    quad_beat_t exp_q;
    if (rst_n && out_valid && !out_stall) begin
      if (quads_due.size() == 0) begin
        report_mismatch("quad beat with nothing expected, src_col", {21'd0, out_src_col}, '0);
      end else begin
        exp_q = quads_due.pop_front();
        check_field("top_left", out_top_left, exp_q.corners.top_left, exp_q);
        check_field("top_right", out_top_right, exp_q.corners.top_right, exp_q);
        check_field("bottom_left", out_bottom_left, exp_q.corners.bottom_left, exp_q);
        check_field("bottom_right", out_bottom_right, exp_q.corners.bottom_right, exp_q);
        check_field("src_col", {21'd0, out_src_col}, {21'd0, exp_q.col}, exp_q);
        check_field("src_row", {20'd0, out_src_row}, {20'd0, exp_q.row}, exp_q);
        check_field("frame_last", {31'd0, out_frame_last}, {31'd0, exp_q.last}, exp_q);
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d quads still due", cycle_count, quads_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall before each quad beat, none in no-idle stretches
  // ---------------------------------------------------------------------------

  initial begin : quad_receiver
    int unsigned hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // stop sending and wait until every quad owed has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (quads_due.size() != 0);
  endtask

  // size registers only change with the block quiet
  task automatic write_reg(input s2x_pkg::cfg_reg_t reg_sel,
                           input logic [s2x_pkg::CFG_DATA_W-1:0] data);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (reg_sel == s2x_pkg::REG_IMAGE_WIDTH) cfg_width = data[s2x_pkg::WIDTH_W-1:0];
    else cfg_height = data[s2x_pkg::HEIGHT_W-1:0];
  endtask

  // one pixel beat; typed rows replace the predicted quad by the one written in the table
  task automatic send_pixel(input logic [31:0] p, input bit typed, input quad_beat_t want);
    int unsigned gap, n0;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
    n0 = quads_due.size();
    predict_quads(p);
    if (typed) begin
      while (quads_due.size() > n0) void'(quads_due.pop_back());
      quads_due.push_back(want);
    end
    pixels_sent++;
  endtask

  // small palettes make equal neighbors common so the corner rule fires often
  task automatic new_palette();
    palette_size = $urandom_range(0, 4);
    foreach (palette[i]) begin
      case ($urandom_range(0, 7))
        0: palette[i] = '0;
        1: palette[i] = '1;
        default: palette[i] = $urandom();
      endcase
    end
  endtask

  function automatic logic [31:0] pick_pixel();
    if (palette_size == 0) return $urandom();
    return palette[$urandom_range(0, palette_size - 1)];
  endfunction

  // random phase: mostly whole frames of a fresh size, sometimes a frame cut short
  // and resized while open (height anywhere, width only shrinking at a row start,
  // so no store entry is ever read before it was written)
  task automatic run_phase();
    int unsigned n, frames;
    no_idle = ($urandom_range(0, 3) == 0);
    new_palette();
    if (col_pos == 0 && row_pos == 0) begin
      if ($urandom_range(0, 9) < 7) begin
        write_reg(s2x_pkg::REG_IMAGE_WIDTH,
                  s2x_pkg::CFG_DATA_W'($urandom_range(1, 8) | ($urandom_range(0, 1) << 12)));
        write_reg(s2x_pkg::REG_IMAGE_HEIGHT, s2x_pkg::CFG_DATA_W'($urandom_range(1, 6)));
      end else begin
        write_reg(s2x_pkg::REG_IMAGE_WIDTH, s2x_pkg::CFG_DATA_W'($urandom_range(0, 40)));
        write_reg(s2x_pkg::REG_IMAGE_HEIGHT, s2x_pkg::CFG_DATA_W'($urandom_range(0, 12)));
      end
    end else begin
      write_reg(s2x_pkg::REG_IMAGE_HEIGHT, s2x_pkg::CFG_DATA_W'($urandom_range(0, 8)));
      if (col_pos == 0 && $urandom_range(0, 1) == 1)
        write_reg(s2x_pkg::REG_IMAGE_WIDTH,
                  s2x_pkg::CFG_DATA_W'($urandom_range(0, eff_width())));
    end
    if ($urandom_range(0, 4) == 0) begin
      // cut the frame short; the next phase resizes it mid-frame
      n = $urandom_range(1, eff_width() * eff_height());
      repeat (n) send_pixel(pick_pixel(), 1'b0, '0);
    end else begin
      frames = $urandom_range(1, 2);
      repeat (frames) begin
        do begin
          send_pixel(pick_pixel(), 1'b0, '0);
          // occasional hold-off until the output side has caught up
          if ($urandom_range(0, 59) == 0) drain_results();
        end while (!(col_pos == 0 && row_pos == 0));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t write_row(s2x_pkg::cfg_reg_t reg_sel, logic [31:0] v);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.reg_sel = reg_sel;
    r.value = v;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t pixel_row(logic [31:0] v);
    stim_row_t r;
    r = write_row(s2x_pkg::REG_IMAGE_WIDTH, v);
    r.kind = ROW_PIXEL;
    return r;
  endfunction

  // a 1x1 frame returns the pixel itself in all four corners, flagged last
  function automatic stim_row_t lone_pixel_row(logic [31:0] v);
    stim_row_t r;
    r = pixel_row(v);
    r.typed = 1'b1;
    r.want.corners = {v, v, v, v};
    r.want.last = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned start, waited;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // single pixel frames: value extremes, then zero sizes acting as one
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 1));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 1));
    plan.push_back(lone_pixel_row(32'h0000_0000));
    plan.push_back(lone_pixel_row(32'hFFFF_FFFF));
    plan.push_back(lone_pixel_row(32'hA5A5_A5A5));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 0));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 0));
    plan.push_back(lone_pixel_row(32'h5A5A_5A5A));
    // one column: clamped neighbors, plain quads
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 1));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 3));
    plan.push_back(pixel_row(32'h0000_0011));
    plan.push_back(pixel_row(32'h0000_0022));
    plan.push_back(pixel_row(32'h0000_0033));
    // one row: everything comes out lagging, flushed at the end
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 3));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 1));
    plan.push_back(pixel_row(32'h0000_0007));
    plan.push_back(pixel_row(32'h0000_0008));
    plan.push_back(pixel_row(32'h0000_0007));
    // 3x3 with a center whose neighbors make the corner rule fire
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 3));
    plan.push_back(pixel_row(32'h0000_0009));
    plan.push_back(pixel_row(32'h0000_0001));
    plan.push_back(pixel_row(32'h0000_0009));
    plan.push_back(pixel_row(32'h0000_0001));
    plan.push_back(pixel_row(32'h0000_0005));
    plan.push_back(pixel_row(32'h0000_0002));
    plan.push_back(pixel_row(32'h0000_0009));
    plan.push_back(pixel_row(32'h0000_0003));
    plan.push_back(pixel_row(32'h0000_0009));
    // height cut while row 1 is open: the next pixel gives all three quads
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 2));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 5));
    plan.push_back(pixel_row(32'h1111_1111));
    plan.push_back(pixel_row(32'h2222_2222));
    plan.push_back(pixel_row(32'h3333_3333));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 2));
    plan.push_back(pixel_row(32'h4444_4444));
    // oversize width on a single row, cut back mid-row so the row ends at once
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 4095));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 1));
    for (int i = 0; i < 20; i++) plan.push_back(pixel_row(32'(i % 3)));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 3));
    plan.push_back(pixel_row(32'h0000_0002));
    // oversize height, cut back after twenty rows of two so the next row ends the frame
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_WIDTH, 2));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 8191));
    for (int i = 0; i < 40; i++) plan.push_back(pixel_row(32'((i * 7) % 5)));
    plan.push_back(write_row(s2x_pkg::REG_IMAGE_HEIGHT, 1));
    plan.push_back(pixel_row(32'h0000_0004));
    plan.push_back(pixel_row(32'h0000_0001));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE)
        write_reg(plan[i].reg_sel, plan[i].value[s2x_pkg::CFG_DATA_W-1:0]);
      else send_pixel(plan[i].value, plan[i].typed, plan[i].want);
    end

    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) run_phase();

    // let the pipeline empty out, then wait SETTLE_CYCLES more for stray beats
    in_valid <= 1'b0;
    waited = 0;
    while (quads_due.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (quads_due.size() != 0) report_mismatch("quads never delivered, count", quads_due.size(), '0);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
